/* sv/bds_pkg.sv */
// Shared constants for the 2x2 box downsampler.
// Field widths, register indexes and reset values; no dependencies.
package bds_pkg;

   // pixel and channel layout
   localparam int PIXEL_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 4;
   localparam int PSUM_W   = CHAN_W + 1;
   localparam int LINE_W   = NUM_CHAN * PSUM_W;

   // configuration registers
   localparam int CFG_W     = 10;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_PAGE_SIZE = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_THREE_CH  = 1'b1;
   localparam logic [CFG_W-1:0] PAGE_SIZE_RESET   = 10'd256;

   // default largest page edge
   localparam int DEF_MAX_PAGE_SIZE = 512;

endpackage

/* sv/bds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bds_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/box_downsample_2x2.sv */
// 2x2 box downsampler: halves a square page of packed pixels in each dimension.
// Depends on bds_pkg and bds_ram.
//
// Pixels of a page_size x page_size page enter in raster order, one request per
// clock while req_tready is high. Even rows leave their horizontal pair sums in
// a line store of MAX_PAGE_SIZE/2 entries; on odd rows each odd column yields
// one pixel whose channels are the truncated means of the 2x2 block, with
// rsp_tlast on the last pixel of the page. Throughput is one pixel per clock
// unless the result channel stalls; a result passes through the registered
// read of the line store, which stage 1 waits for, and then the result register.
// The line store needs no clearing after reset. Odd page sizes are rounded
// down, sizes below two act as two and sizes above MAX_PAGE_SIZE are clamped.
// In three-channel mode the top byte of each result is zero.
module box_downsample_2x2 import bds_pkg::*; #(
   parameter int MAX_PAGE_SIZE = DEF_MAX_PAGE_SIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIXEL_W-1:0]   req_tdata,   // [31:0] pixel
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIXEL_W-1:0]   rsp_tdata,   // [31:0] averaged_pixel
   output logic                 rsp_tlast,   // last_of_page
   // configuration
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int LINE_DEPTH = MAX_PAGE_SIZE / 2;
   localparam int EVEN_MAX   = LINE_DEPTH * 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int CNT_W      = (MAX_PAGE_SIZE > 1) ? $clog2(MAX_PAGE_SIZE) : 1;
   localparam int SIZE_W     = (CFG_W > CNT_W + 1) ? CFG_W : CNT_W + 1;
   localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(EVEN_MAX);

   // per-channel sum of two pixels, 9 bits each
   function automatic logic [LINE_W-1:0] pair_sum(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
      logic [LINE_W-1:0] r;
      r = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         r[k*PSUM_W +: PSUM_W] = PSUM_W'(a[k*CHAN_W +: CHAN_W])
                               + PSUM_W'(b[k*CHAN_W +: CHAN_W]);
      end
      return r;
   endfunction

   logic [CFG_W-1:0]   page_size_ff, page_size_in;
   logic               three_ch_ff, three_ch_in;
   logic [PIXEL_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [LINE_W-1:0]  s1_cur_ff, s1_cur_in;
   logic               s1_last_ff, s1_last_in;
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   logic [SIZE_W-1:0]  size_even, size_eff, size_m1;
   logic               req_take, odd_col, odd_row, row_end, row_last;
   logic               emit, store, out_free, s1_advance;
   logic [LINE_W-1:0]  cur_sum, above_sum;
   logic [ADDR_W-1:0]  line_addr;
   logic [PSUM_W:0]    quad_sum [NUM_CHAN];

   // configuration registers
   always_comb begin
      page_size_in = page_size_ff;
      three_ch_in  = three_ch_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PAGE_SIZE: page_size_in = csr_wdata;
            REG_THREE_CH:  three_ch_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RESET;
         three_ch_ff  <= 1'b0;
      end else begin
         page_size_ff <= page_size_in;
         three_ch_ff  <= three_ch_in;
      end
   end

   // effective page edge: even, at least two, at most the line store allows
   always_comb begin
      size_even = SIZE_W'({page_size_ff[CFG_W-1:1], 1'b0});
      if (size_even < SIZE_MIN) begin
         size_eff = SIZE_MIN;
      end else if (size_even > SIZE_MAX) begin
         size_eff = SIZE_MAX;
      end else begin
         size_eff = size_even;
      end
      size_m1 = size_eff - SIZE_W'(1);
   end

   // handshake: the result register frees stage 1, stage 1 frees the input
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   // position decode for the incoming pixel
   assign odd_col   = col_ff[0];
   assign odd_row   = row_ff[0];
   assign row_end   = SIZE_W'(col_ff) >= size_m1;
   assign row_last  = SIZE_W'(row_ff) >= size_m1;
   assign emit      = req_take && odd_col && odd_row;
   assign store     = req_take && odd_col && !odd_row;
   assign cur_sum   = pair_sum(held_ff, req_tdata);
   assign line_addr = ADDR_W'(col_ff >> 1);

   bds_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (line_addr),
      .wr_data (cur_sum),
      .rd_en   (emit),
      .rd_addr (line_addr),
      .rd_data (above_sum)
   );

   // position counters and held even-column pixel
   always_comb begin
      held_in = held_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_take) begin
         if (!odd_col) begin
            held_in = req_tdata;
         end
         if (row_end) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // stage 1: current pair sum waits for the line store read
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cur_in   = s1_cur_ff;
      s1_last_in  = s1_last_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
         s1_cur_in   = cur_sum;
         s1_last_in  = row_end && row_last;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_cur_ff  <= s1_cur_in;
      s1_last_ff <= s1_last_in;
   end

   // averaging: four-pixel sum per channel, divided by four
   always_comb begin
      out_data_in = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         quad_sum[k] = (PSUM_W + 1)'(above_sum[k*PSUM_W +: PSUM_W])
                     + (PSUM_W + 1)'(s1_cur_ff[k*PSUM_W +: PSUM_W]);
         out_data_in[k*CHAN_W +: CHAN_W] = quad_sum[k][PSUM_W:2];
      end
      if (three_ch_ff) begin
         out_data_in[(NUM_CHAN-1)*CHAN_W +: CHAN_W] = '0;
      end
      out_last_in = s1_last_ff;
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (s1_advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // a stalled stage 1 keeps its pair sum while the read data waits
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_cur_ff))
      else $error("stage 1 lost its pair sum while stalled");

   // column position never runs past the widest row
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CNT_W'(EVEN_MAX - 1))
      else $error("column counter out of range");

   // input is only held off while stage 1 is occupied
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff)
      else $error("request stalled with free pipeline");

   // a stage 1 item moves into the result register with its page flag
   a_last: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_tvalid && (rsp_tlast == $past(s1_last_ff)))
      else $error("result register missed stage 1 item");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for box_downsample_2x2.
// Depends on bds_pkg and the RTL of the block; predicts every averaged pixel
// in step with accepted requests and checks results in order.
module tb_top;
   import bds_pkg::*;

   localparam int LINE_DEPTH   = DEF_MAX_PAGE_SIZE / 2;
   localparam int EVEN_MAX     = LINE_DEPTH * 2;
   localparam int DRAIN_TAIL   = 4;     // idle clocks after the last expected result
   localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } avg_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIXEL_W-1:0]   req_tdata = '0;   // [31:0] pixel
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]   rsp_tdata;        // [31:0] averaged_pixel
   logic                 rsp_tlast;        // last_of_page
   logic                 csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // shadow of the block: registers, line store, position in the page
   logic [CFG_W-1:0]     cfg_page_size = PAGE_SIZE_RESET;
   logic                 cfg_three_ch  = 1'b0;
   logic [LINE_W-1:0]    pair_sums [LINE_DEPTH];
   logic [PIXEL_W-1:0]   held_px = '0;
   int unsigned          col_pos = 0;
   int unsigned          row_pos = 0;

   avg_result_type       avg_expected [$];

   int unsigned          req_idle_pct = 0;
   int unsigned          rsp_stall_pct = 0;
   int unsigned          mismatches = 0;
   int unsigned          requests_sent = 0;
   int unsigned          results_checked = 0;
   int unsigned          pages_done = 0;
   int unsigned          quiet_cycles = 0;
   int unsigned          min_size = EVEN_MAX;
   int unsigned          max_size = 0;

   box_downsample_2x2 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned effective_edge();
      int unsigned s;
      s = cfg_page_size & 10'h3FE;
      if (s < 2) s = 2;
      if (s > EVEN_MAX) s = EVEN_MAX;
      return s;
   endfunction

   function automatic logic [LINE_W-1:0] horiz_sum(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
      logic [LINE_W-1:0] r;
      r = '0;
      for (int k = 0; k < NUM_CHAN; k++)
         r[k*PSUM_W +: PSUM_W] = PSUM_W'(a[k*CHAN_W +: CHAN_W]) +
                                 PSUM_W'(b[k*CHAN_W +: CHAN_W]);
      return r;
   endfunction

   // advance the shadow by one pixel; odd column of an odd row yields a result
   task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
      int unsigned       edge_px;
      int unsigned       idx;
      logic              row_end;
      logic [LINE_W-1:0] cur;
      logic [LINE_W-1:0] above;
      logic [PSUM_W:0]   quad;
      avg_result_type    res;
      edge_px = effective_edge();
      idx     = col_pos >> 1;
      row_end = (col_pos >= edge_px - 1);
      if (col_pos[0] == 1'b0) begin
         held_px = px;
      end else begin
         cur = horiz_sum(held_px, px);
         if (row_pos[0] == 1'b0) begin
            pair_sums[idx] = cur;
         end else begin
            above = pair_sums[idx];
            res.pixel = '0;
            for (int k = 0; k < NUM_CHAN; k++) begin
               quad = (PSUM_W+1)'(above[k*PSUM_W +: PSUM_W]) +
                      (PSUM_W+1)'(cur[k*PSUM_W +: PSUM_W]);
               if (!(k == NUM_CHAN - 1 && cfg_three_ch))
                  res.pixel[k*CHAN_W +: CHAN_W] = quad[CHAN_W+1:2];
            end
            res.last = row_end && (row_pos >= edge_px - 1);
            avg_expected.push_back(res);
         end
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = (row_pos >= edge_px - 1) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string what, input avg_result_type want,
                                input avg_result_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch (%s): expected %08h last %0b, got %08h last %0b",
                  what, want.pixel, want.last, got.pixel, got.last);
   endtask

   always @(posedge clock) begin
      avg_result_type got;
      avg_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pixel = rsp_tdata;
         got.last  = rsp_tlast;
         if (avg_expected.size() == 0) begin
            note_mismatch("result with none pending", '0, got);
         end else begin
            want = avg_expected.pop_front();
            if (got.pixel !== want.pixel || got.last !== want.last)
               note_mismatch("averaged pixel", want, got);
            results_checked++;
            if (want.last) pages_done++;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  quiet_cycles, avg_expected.size());
         $display("box_downsample_2x2 regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(px);
      requests_sent++;
   endtask

   task automatic send_block(input logic [PIXEL_W-1:0] p0, input logic [PIXEL_W-1:0] p1,
                             input logic [PIXEL_W-1:0] p2, input logic [PIXEL_W-1:0] p3);
      send_pixel(p0);
      send_pixel(p1);
      send_pixel(p2);
      send_pixel(p3);
   endtask

   // hold the sender until every pending result has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (avg_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CFG_W-1:0] edge_val, input logic three_ch);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= REG_PAGE_SIZE;
      csr_wdata <= edge_val;
      @(posedge clock);
      cfg_page_size = edge_val;
      csr_index <= REG_THREE_CH;
      csr_wdata <= CFG_W'(three_ch);
      @(posedge clock);
      cfg_three_ch = three_ch;
      csr_we <= 1'b0;
      if (effective_edge() < min_size) min_size = effective_edge();
      if (effective_edge() > max_size) max_size = effective_edge();
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      logic [PIXEL_W-1:0] p;
      p = $urandom();
      case ($urandom_range(9))
         0, 1: for (int k = 0; k < NUM_CHAN; k++)
                  p[k*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
         2:    p = p & 32'h0303_0303;
         default: ;
      endcase
      return p;
   endfunction

   // mostly small pages; now and then odd, tiny or oversized values
   function automatic logic [CFG_W-1:0] pick_page_size();
      case ($urandom_range(9))
         0:       return CFG_W'($urandom_range(1023));
         1:       return CFG_W'($urandom_range(1));
         default: return CFG_W'($urandom_range(2, 16));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // clamp of an oversized edge; the first row fills the whole line store
   task automatic test_largest_page();
      write_regs(10'd1023, 1'b0);
      repeat (EVEN_MAX) send_pixel(pick_pixel());
      // shrink part-way down the page: rows carry on from where they stand
      write_regs(10'd6, 1'b1);
      repeat (30) send_pixel(pick_pixel());
      drain_results();
   endtask

   task automatic test_channel_extremes();
      write_regs(10'd2, 1'b0);
      send_block('1, '1, '1, '1);
      send_block('0, '0, '0, '0);
      send_block(32'h0303_0303, '0, '0, '0);            // sums of 3 truncate to 0
      send_block('1, '1, '1, 32'hFEFE_FEFE);            // 1019 / 4
      send_block(32'h0100_00FF, 32'h0001_00FF, 32'h0000_01FF, 32'hFF00_0000);
      write_regs(10'd2, 1'b1);
      send_block('1, '1, '1, '1);                       // top byte forced to zero
   endtask

   task automatic test_edge_rounding();
      write_regs(10'd3, 1'b0);                          // odd, rounds down to 2
      send_block(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
      write_regs(10'd0, 1'b0);                          // below two acts as two
      send_block(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
      write_regs(10'd1, 1'b1);
      send_block(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel());
      write_regs(10'd5, 1'b0);
      repeat (16) send_pixel(pick_pixel());
   endtask

   // the mode applies when a result forms, not when pair sums are stored
   task automatic test_mode_mid_page();
      write_regs(10'd4, 1'b0);
      repeat (4) send_pixel(pick_pixel());
      write_regs(10'd4, 1'b1);
      repeat (4) send_pixel(pick_pixel());
      write_regs(10'd4, 1'b0);
      repeat (8) send_pixel(pick_pixel());
      drain_results();
   endtask

   task automatic test_random_phase(input int unsigned idle_pct,
                                    input int unsigned stall_pct,
                                    input int unsigned n_items);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      write_regs(pick_page_size(), 1'($urandom_range(1)));
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i == n_items / 2)
            write_regs(pick_page_size(), 1'($urandom_range(1)));
         else if ($urandom_range(59) == 0)
            drain_results();
         send_pixel(pick_pixel());
      end
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_largest_page();
      test_channel_extremes();
      test_edge_rounding();
      test_mode_mid_page();
      test_random_phase(0, 0, 125);
      test_random_phase(50, 0, 125);
      test_random_phase(0, 50, 125);
      test_random_phase(37, 37, 125);

      drain_results();
      repeat (2 * DRAIN_TAIL) @(posedge clock);
      $display("sent %0d pixels, checked %0d averaged pixels over %0d completed pages",
               requests_sent, results_checked, pages_done);
      $display("page edges %0d to %0d, both channel modes, idle and stall phases",
               min_size, max_size);
      if (mismatches == 0) begin
         $display("box_downsample_2x2 regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("box_downsample_2x2 regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/bds_pkg.sv
sv/bds_ram.sv
sv/box_downsample_2x2.sv
tb/tb_top.sv
